/* hw/rtl/sih_pkg.sv */
// ----------------------------------------------------------------------------
// sih_pkg
// Shared types, constants and a helper function for the string intern table.
// ----------------------------------------------------------------------------
package sih_pkg;

  localparam int STORE_BYTES_DEF        = 65536;
  localparam int MAX_BUCKETS_DEF        = 16;
  localparam int ENTRIES_PER_BUCKET_DEF = 128;

  localparam int HASH_ROTATE = 7;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_CASE_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_BITS = 1'd1;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_STORE_FULL  = 2'd1;
  localparam logic [1:0] ST_BUCKET_FULL = 2'd2;

  typedef struct packed {
    logic       opcode;
    logic [7:0] char_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] string_offset;
    logic        already_present;
    logic [1:0]  status_code;
    logic [11:0] strings_held;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic take_byte;     // store byte, update hash
    logic clear;         // empty the table
    logic end_start;     // latch hash and length, check store room
    logic scan_rd;       // read entry scan_idx of bucket
    logic scan_chk;      // compare key of entry just read
    logic cmp_rd;        // read one byte pair
    logic cmp_chk;       // compare byte pair just read
    logic insert;        // record new entry
    logic finish;        // build result
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic store_full;
    logic scan_done;     // no more entries in bucket
    logic key_hit;
    logic cmp_mismatch;
    logic cmp_match;
  } sts_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic mode);
    if (mode && c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
    return c;
  endfunction

endpackage

/* hw/rtl/string_intern_hash_table.sv */
// ----------------------------------------------------------------------------
// string_intern_hash_table
// String interning table: bytes in, offset of the unique copy out.
// ----------------------------------------------------------------------------
// Input items carry an opcode and one string byte. A nonzero byte is stored
// and hashed, so bytes stream at one a cycle with no result while the table
// is idle. A zero byte starts the lookup: a start step checks store room,
// then each entry of the bucket is read and its key checked, and on each key
// hit the strings are compared byte by byte through the single byte store. A
// miss sees the end of the bucket and then inserts, and a last step builds
// the result. A string that does not fit goes from the start step straight to
// building the result. The input stalls from the zero byte until the result
// is built. One result transfer follows each zero byte; the result register
// holds it while the receiver stalls, and the next string's bytes are taken
// meanwhile, but its zero byte waits. A clear item empties the table. The
// user must write configuration through cfg_we, cfg_index and cfg_data only
// while idle; the block does not enforce this. Reset empties the table and
// sets case-insensitive mode with one bucket; the stores need no clearing
// pass.
// ----------------------------------------------------------------------------
module string_intern_hash_table
  import sih_pkg::*;
#(
  parameter int STORE_BYTES        = STORE_BYTES_DEF,
  parameter int MAX_BUCKETS        = MAX_BUCKETS_DEF,
  parameter int ENTRIES_PER_BUCKET = ENTRIES_PER_BUCKET_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic       case_mode_r;
  logic [2:0] bucket_bits_r;
  cmd_t       cmd;
  sts_t       sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      case_mode_r   <= 1'b1;
      bucket_bits_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CASE_MODE:   case_mode_r   <= cfg_data[0];
        CFG_BUCKET_BITS: bucket_bits_r <= cfg_data;
        default: ;
      endcase
    end
  end

  sih_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .cmd, .sts
  );

  sih_dpath #(
    .STORE_BYTES(STORE_BYTES), .MAX_BUCKETS(MAX_BUCKETS),
    .ENTRIES_PER_BUCKET(ENTRIES_PER_BUCKET)
  ) u_dpath (
    .clk, .rst_n, .case_mode(case_mode_r), .bucket_bits(bucket_bits_r),
    .in_data, .cmd, .sts, .out_data
  );

endmodule

/* hw/rtl/sih_ctrl.sv */
// ----------------------------------------------------------------------------
// sih_ctrl
// Sequencer for byte intake, bucket scan, byte compare and result hand-off.
// ----------------------------------------------------------------------------
module sih_ctrl
  import sih_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output cmd_t      cmd,
  input  sts_t      sts
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_START    = 8'b0000_0010,
    S_SCAN_RD  = 8'b0000_0100,
    S_SCAN_CHK = 8'b0000_1000,
    S_CMP_RD   = 8'b0001_0000,
    S_CMP_CHK  = 8'b0010_0000,
    S_INSERT   = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  wire in_fire = in_valid && !in_stall;

  // Bytes are taken only in IDLE; the result register frees while a new
  // string streams in.
  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && in_data.opcode == OP_BYTE
                      && in_data.char_byte == 8'd0 && out_stall);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.opcode == OP_CLEAR) begin
            cmd.clear = 1'b1;
          end else if (in_data.char_byte != 8'd0) begin
            cmd.take_byte = 1'b1;
          end else begin
            cmd.end_start = 1'b1;
            state_nxt     = S_START;
          end
        end
      end
      S_START: begin
        if (sts.store_full) state_nxt = S_DONE;
        else                state_nxt = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        if (sts.scan_done) begin
          state_nxt = S_INSERT;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        cmd.scan_chk = 1'b1;
        if (sts.key_hit) state_nxt = S_CMP_RD;
        else             state_nxt = S_SCAN_RD;
      end
      S_CMP_RD: begin
        cmd.cmp_rd = 1'b1;
        state_nxt  = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        cmd.cmp_chk = 1'b1;
        if (sts.cmp_match)         state_nxt = S_DONE;
        else if (sts.cmp_mismatch) state_nxt = S_SCAN_RD;
        else                       state_nxt = S_CMP_RD;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hw/rtl/sih_dpath.sv */
// ----------------------------------------------------------------------------
// sih_dpath
// Byte store, bucket tables, hash, cursors and result register.
// ----------------------------------------------------------------------------
module sih_dpath
  import sih_pkg::*;
#(
  parameter int STORE_BYTES        = STORE_BYTES_DEF,
  parameter int MAX_BUCKETS        = MAX_BUCKETS_DEF,
  parameter int ENTRIES_PER_BUCKET = ENTRIES_PER_BUCKET_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      case_mode,
  input  logic [2:0] bucket_bits,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  output sts_t      sts,
  output out_item_t out_data
);

  localparam int AW  = $clog2(STORE_BYTES);
  localparam int LW  = AW + 1;
  localparam int BW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int EW  = $clog2(ENTRIES_PER_BUCKET);
  localparam int FW  = EW + 1;
  localparam int TD  = MAX_BUCKETS * ENTRIES_PER_BUCKET;
  localparam int TW  = $clog2(TD);
  localparam logic [LW-1:0] STORE_LIM  = LW'(STORE_BYTES);
  localparam logic [FW-1:0] ENTRY_LIM  = FW'(ENTRIES_PER_BUCKET);

  logic [7:0]  store_mem [STORE_BYTES];
  logic [31:0] key_mem   [TD];
  logic [AW-1:0] off_mem [TD];

  logic [FW-1:0] fill_r [MAX_BUCKETS];
  logic [LW-1:0] cursor_r, plen_r, len_r;
  logic [31:0]   hash_r, key_r;
  logic [11:0]   total_r;
  logic [BW-1:0] bucket_r;
  logic [FW-1:0] scan_idx_r;
  logic [AW-1:0] cand_off_r, hit_off_r;
  logic [LW-1:0] cmp_i_r;
  logic [7:0]    byte_a_r, byte_b_r;
  logic          cmp_ok_r;
  logic          store_full_r, present_r;
  out_item_t     out_r;

  // Bucket from the low hash bits; the wrap to the bucket count is a
  // constant table over the at most 128 masked values.
  logic [6:0]    mask_h;
  logic [BW-1:0] bucket_w;
  assign mask_h = hash_r[6:0] & 7'((8'd1 << bucket_bits) - 8'd1);

  always_comb begin
    bucket_w = '0;
    for (int m = 0; m < 128; m++) begin
      if (mask_h == 7'(m)) bucket_w = BW'(m % MAX_BUCKETS);
    end
  end

  wire [LW:0] need_w = {1'b0, cursor_r} + {1'b0, plen_r} + (LW+1)'(1);
  wire [TW-1:0] tab_idx = TW'(bucket_r) * TW'(ENTRIES_PER_BUCKET) + TW'(scan_idx_r);
  wire [TW-1:0] ins_idx = TW'(bucket_r) * TW'(ENTRIES_PER_BUCKET)
                          + TW'(fill_r[bucket_r]);

  wire [LW:0]   pos_w = {1'b0, cursor_r} + {1'b0, plen_r};
  wire [LW:0]   pa_w  = {1'b0, cursor_r} + {1'b0, cmp_i_r};
  wire [LW:0]   pb_w  = (LW+1)'(cand_off_r) + {1'b0, cmp_i_r};
  logic         pair_out_r;

  wire [7:0] fa = fold_byte(byte_a_r, case_mode);
  wire [7:0] fb = fold_byte(byte_b_r, case_mode);

  assign sts.store_full   = store_full_r;
  assign sts.scan_done    = (scan_idx_r >= fill_r[bucket_r]) || (scan_idx_r >= ENTRY_LIM);
  assign sts.key_hit      = (key_r == hash_r);
  assign sts.cmp_mismatch = pair_out_r || (fa != fb) || (cmp_i_r >= len_r);
  assign sts.cmp_match    = !pair_out_r && (fa == fb) && (fa == 8'd0)
                            && (cmp_i_r < len_r);

  // Memories.
  always_ff @(posedge clk) begin
    if (cmd.take_byte && pos_w < (LW+1)'(STORE_BYTES))
      store_mem[pos_w[AW-1:0]] <= in_data.char_byte;
    if (cmd.end_start && need_w <= (LW+1)'(STORE_BYTES))
      store_mem[pos_w[AW-1:0]] <= 8'd0;
    if (cmd.cmp_rd) begin
      byte_a_r <= store_mem[pa_w[AW-1:0]];
      byte_b_r <= store_mem[pb_w[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert && fill_r[bucket_r] < ENTRY_LIM) begin
      key_mem[ins_idx] <= hash_r;
      off_mem[ins_idx] <= cursor_r[AW-1:0];
    end
    if (cmd.scan_rd) begin
      key_r      <= key_mem[tab_idx];
      cand_off_r <= off_mem[tab_idx];
    end
  end

  // Compare-pair position check.
  always_ff @(posedge clk) begin
    if (cmd.cmp_rd)
      pair_out_r <= (pa_w >= (LW+1)'(STORE_BYTES)) || (pb_w >= (LW+1)'(STORE_BYTES));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r     <= '0;
      plen_r       <= '0;
      hash_r       <= '0;
      total_r      <= '0;
      store_full_r <= 1'b0;
      present_r    <= 1'b0;
      scan_idx_r   <= '0;
      cmp_i_r      <= '0;
      len_r        <= '0;
      bucket_r     <= '0;
      for (int b = 0; b < MAX_BUCKETS; b++) fill_r[b] <= '0;
    end else begin
      if (cmd.clear) begin
        cursor_r <= '0;
        plen_r   <= '0;
        hash_r   <= '0;
        total_r  <= '0;
        for (int b = 0; b < MAX_BUCKETS; b++) fill_r[b] <= '0;
      end
      if (cmd.take_byte) begin
        if (plen_r < STORE_LIM) plen_r <= plen_r + LW'(1);
        hash_r <= {hash_r[31-HASH_ROTATE:0], hash_r[31:32-HASH_ROTATE]}
                  + {24'd0, fold_byte(in_data.char_byte, case_mode)};
      end
      if (cmd.end_start) begin
        // Hash stays for the scan; it is zeroed when the result is built.
        len_r        <= LW'(plen_r + LW'(1));
        store_full_r <= need_w > (LW+1)'(STORE_BYTES);
        bucket_r     <= bucket_w;
        scan_idx_r   <= '0;
        present_r    <= 1'b0;
        plen_r       <= '0;
      end
      if (cmd.scan_rd) cmp_i_r <= '0;
      if (cmd.scan_chk && !sts.key_hit) scan_idx_r <= scan_idx_r + FW'(1);
      if (cmd.cmp_chk) begin
        cmp_i_r <= cmp_i_r + LW'(1);
        if (sts.cmp_match) begin
          present_r <= 1'b1;
          hit_off_r <= cand_off_r;
        end else if (sts.cmp_mismatch) begin
          scan_idx_r <= scan_idx_r + FW'(1);
        end
      end
      if (cmd.insert && fill_r[bucket_r] < ENTRY_LIM) begin
        fill_r[bucket_r] <= fill_r[bucket_r] + FW'(1);
        cursor_r         <= cursor_r + len_r;
        total_r          <= total_r + 12'd1;
        hit_off_r        <= cursor_r[AW-1:0];
      end
      if (cmd.finish) hash_r <= '0;
    end
  end

  // Insert after a miss fails when the bucket is already full.
  logic bfull_r;
  always_ff @(posedge clk) begin
    if (cmd.end_start) bfull_r <= 1'b0;
    if (cmd.insert)    bfull_r <= !(fill_r[bucket_r] < ENTRY_LIM);
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r.strings_held <= total_r;
      if (store_full_r) begin
        out_r.string_offset   <= '0;
        out_r.already_present <= 1'b0;
        out_r.status_code     <= ST_STORE_FULL;
      end else if (present_r) begin
        out_r.string_offset   <= 16'(hit_off_r);
        out_r.already_present <= 1'b1;
        out_r.status_code     <= ST_OK;
      end else if (bfull_r) begin
        out_r.string_offset   <= '0;
        out_r.already_present <= 1'b0;
        out_r.status_code     <= ST_BUCKET_FULL;
      end else begin
        out_r.string_offset   <= 16'(hit_off_r);
        out_r.already_present <= 1'b0;
        out_r.status_code     <= ST_OK;
      end
    end
  end

  assign out_data = out_r;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the string intern table.
// ----------------------------------------------------------------------------
// A short directed table runs first. Random strings over several register
// settings follow. Then the testbench fills one bucket until it is full and
// sends two more strings into it. Every result transfer is checked, against
// the directed expectations or an in-bench model of the table.
// ----------------------------------------------------------------------------
module tb_top;
  import sih_pkg::*;

  localparam int STORE  = STORE_BYTES_DEF;
  localparam int NBUCK  = MAX_BUCKETS_DEF;
  localparam int DEPTH  = ENTRIES_PER_BUCKET_DEF;
  localparam int LIMIT  = 2000000;
  localparam int RANDOM_ITEMS = 440;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  string_intern_hash_table u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Model state of the table.
  logic [7:0]  mirror_bytes [0:STORE-1];
  logic [31:0] mirror_keys  [0:NBUCK*DEPTH-1];
  int          mirror_offs  [0:NBUCK*DEPTH-1];
  int          mirror_fill  [0:NBUCK-1];
  int          cursor_pos;
  int          partial_len;
  logic [31:0] partial_hash;
  int          interned_count;
  logic        fold_mode;
  logic [2:0]  mask_bits;

  out_item_t   lookups_due[$];
  int          mismatch_count;
  int          cycle_count;
  bit          sender_burst;
  bit          receiver_burst;
  bit          long_hold_req;

  typedef struct {
    logic       op;
    logic [7:0] ch;
    bit         typed;
    out_item_t  want;
  } row_t;

  row_t directed_rows[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] fold_char(logic [7:0] c, logic m);
    if (m && c >= "A" && c <= "Z") return c - "A" + "a";
    return c;
  endfunction

  function automatic bit strings_equal(int off, int len);
    int i;
    logic [7:0] ca, cb;
    for (i = 0; i < len; i++) begin
      if (cursor_pos + i >= STORE || off + i >= STORE) return 0;
      ca = fold_char(mirror_bytes[cursor_pos + i], fold_mode);
      cb = fold_char(mirror_bytes[off + i], fold_mode);
      if (ca != cb) return 0;
      if (ca == 8'd0) return 1;
    end
    return 0;
  endfunction

  function automatic void intern_predict(in_item_t it, output bit has_result,
                                         output out_item_t res);
    logic [31:0] h;
    int len, bkt, base, i, pos;
    bit hit;
    has_result = 0;
    res = '0;
    hit = 0;
    if (it.opcode == OP_CLEAR) begin
      for (i = 0; i < NBUCK; i++) mirror_fill[i] = 0;
      cursor_pos = 0;
      partial_len = 0;
      partial_hash = '0;
      interned_count = 0;
      return;
    end
    if (it.char_byte != 8'd0) begin
      pos = cursor_pos + partial_len;
      if (pos < STORE) mirror_bytes[pos] = it.char_byte;
      if (partial_len < STORE) partial_len++;
      partial_hash = {partial_hash[24:0], partial_hash[31:25]}
                     + 32'(fold_char(it.char_byte, fold_mode));
      return;
    end
    has_result = 1;
    h = partial_hash;
    len = partial_len + 1;
    partial_hash = '0;
    partial_len = 0;
    if (cursor_pos + len > STORE) begin
      res.status_code = ST_STORE_FULL;
    end else begin
      mirror_bytes[cursor_pos + len - 1] = 8'd0;
      bkt = int'(h & ((32'd1 << mask_bits) - 1)) % NBUCK;
      base = bkt * DEPTH;
      for (i = 0; i < mirror_fill[bkt] && i < DEPTH && !hit; i++) begin
        if (mirror_keys[base + i] == h && strings_equal(mirror_offs[base + i], len)) begin
          res.string_offset = 16'(mirror_offs[base + i]);
          res.already_present = 1'b1;
          hit = 1;
        end
      end
      if (!hit) begin
        if (mirror_fill[bkt] >= DEPTH) begin
          res.status_code = ST_BUCKET_FULL;
        end else begin
          mirror_keys[base + mirror_fill[bkt]] = h;
          mirror_offs[base + mirror_fill[bkt]] = cursor_pos;
          mirror_fill[bkt]++;
          res.string_offset = 16'(cursor_pos);
          cursor_pos += len;
          interned_count++;
        end
      end
    end
    res.strings_held = 12'(interned_count);
  endfunction

  // Offers one item after a random gap and waits for its transfer.
  task automatic send_item(logic op, logic [7:0] ch, bit typed, out_item_t want);
    int gap;
    bit has_result;
    out_item_t res;
    gap = sender_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data.opcode <= op;
    in_data.char_byte <= ch;
    do @(posedge clk); while (in_stall);
    intern_predict('{opcode: op, char_byte: ch}, has_result, res);
    if (has_result) lookups_due.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  task automatic send_string(logic [7:0] s[$]);
    foreach (s[k]) send_item(OP_BYTE, s[k], 0, '0);
    send_item(OP_BYTE, 8'd0, 0, '0);
  endtask

  task automatic settle_and_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (lookups_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CASE_MODE) fold_mode = val[0];
    else mask_bits = val;
  endtask

  function automatic row_t row(logic op, logic [7:0] ch, bit typed = 0,
                               int off = 0, bit pres = 0, int held = 0);
    row_t r;
    r.op = op;
    r.ch = ch;
    r.typed = typed;
    r.want = '{string_offset: 16'(off), already_present: pres,
               status_code: ST_OK, strings_held: 12'(held)};
    return r;
  endfunction

  // Result side: random stall before each transfer, plus one long hold-off.
  initial begin
    int n;
    out_item_t want;
    out_stall = 1'b1;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        n = 400;
        long_hold_req = 0;
      end else begin
        n = receiver_burst ? 0 : $urandom_range(0, 16);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      if (lookups_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result transfer: %p", out_data);
      end else begin
        want = lookups_due.pop_front();
        if (out_data !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected %p, got %p", want, out_data);
        end
      end
      @(negedge clk);
    end
  end

  // Toggles back-to-back stretches on both sides now and then.
  initial begin
    forever begin
      repeat ($urandom_range(50, 300)) @(negedge clk);
      sender_burst = ($urandom_range(0, 3) == 0);
      receiver_burst = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    logic [7:0] word_pool[12][$];
    logic [7:0] s[$];
    logic [2:0] phase_bits[6] = '{3'd4, 3'd7, 3'd2, 3'd5, 3'd3, 3'd0};
    logic       phase_mode[6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    int sent, p, w, k, len;
    logic [7:0] c;

    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycle_count = 0;
    mismatch_count = 0;
    sender_burst = 0;
    receiver_burst = 0;
    long_hold_req = 0;
    fold_mode = 1'b1;
    mask_bits = '0;
    cursor_pos = 0;
    partial_len = 0;
    partial_hash = '0;
    interned_count = 0;
    for (k = 0; k < NBUCK; k++) mirror_fill[k] = 0;

    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset values: case-insensitive, one bucket.
    directed_rows = '{
      row(OP_BYTE, "a"),
      row(OP_BYTE, 8'd0, 1, 0, 0, 1),
      row(OP_BYTE, "A"),
      row(OP_BYTE, 8'd0, 1, 0, 1, 1),
      row(OP_BYTE, 8'd0, 1, 2, 0, 2),
      row(OP_BYTE, 8'd0, 1, 2, 1, 2),
      row(OP_BYTE, 8'hFF),
      row(OP_BYTE, 8'h80),
      row(OP_BYTE, 8'h01),
      row(OP_BYTE, 8'd0, 1, 3, 0, 3),
      row(OP_BYTE, "Z"),
      row(OP_BYTE, "q"),
      row(OP_CLEAR, 8'hFF),
      row(OP_BYTE, 8'd0, 1, 0, 0, 1),
      row(OP_CLEAR, 8'd0),
      row(OP_BYTE, "M"),
      row(OP_BYTE, 8'd0, 1, 0, 0, 1),
      row(OP_BYTE, "m"),
      row(OP_BYTE, 8'd0, 1, 0, 1, 1),
      row(OP_BYTE, 8'h7F),
      row(OP_BYTE, 8'd0)
    };
    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].typed,
                directed_rows[i].want);

    sent = 0;
    for (p = 0; p < 6; p++) begin
      settle_and_write(CFG_CASE_MODE, {2'b00, phase_mode[p]});
      settle_and_write(CFG_BUCKET_BITS, phase_bits[p]);
      if (p == 0) long_hold_req = 1;
      for (w = 0; w < 12; w++) begin
        word_pool[w] = {};
        len = $urandom_range(0, 6);
        for (k = 0; k < len; k++)
          word_pool[w].push_back(8'(($urandom_range(0, 1) ? "A" : "a") + $urandom_range(0, 25)));
      end
      while (sent < (p + 1) * RANDOM_ITEMS / 6) begin
        s = {};
        case ($urandom_range(0, 19))
          0: begin
            // A clear, sometimes dropping a partly sent string.
            if ($urandom_range(0, 1)) begin
              send_item(OP_BYTE, 8'($urandom_range(1, 255)), 0, '0);
              sent++;
            end
            send_item(OP_CLEAR, 8'($urandom_range(0, 255)), 0, '0);
            sent++;
          end
          1, 2, 3: begin
            len = $urandom_range(0, 5);
            for (k = 0; k < len; k++) s.push_back(8'($urandom_range(1, 255)));
            send_string(s);
            sent += len + 1;
          end
          default: begin
            // A pool word with the case of its letters flipped at random.
            s = word_pool[$urandom_range(0, 11)];
            foreach (s[k]) begin
              c = s[k];
              if ($urandom_range(0, 3) == 0) c = c ^ 8'h20;
              s[k] = c;
            end
            send_string(s);
            sent += s.size() + 1;
          end
        endcase
      end
    end

    // One bucket fills up, and the last strings find it full.
    settle_and_write(CFG_CASE_MODE, 3'd0);
    settle_and_write(CFG_BUCKET_BITS, 3'd0);
    send_item(OP_CLEAR, 8'd0, 0, '0);
    for (k = 0; k < DEPTH + 2; k++) begin
      s = {8'(8'h21 + (k >> 3)), 8'(8'h61 + (k & 7))};
      send_string(s);
    end
    in_valid <= 1'b0;

    while (lookups_due.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
